[src/ctsd_pkg.sv]
// shared types and constants for the column trough spacing detector
`timescale 1ns / 1ps
`default_nettype none
package ctsd_pkg;

	localparam int PIX_W   = 8;
	localparam int OUT_W   = 12;
	localparam int CFG_W   = 13;
	localparam int CFG_A_W = 2;

	localparam logic [12:0] FRAME_ROWS_RST = 13'd4096;
	localparam logic [7:0]  NEAR_THR_RST   = 8'd10;
	localparam logic [7:0]  CONTR_THR_RST  = 8'd25;
	localparam logic [11:0] PLATEAU_RST    = 12'd10;

	typedef enum logic [CFG_A_W-1:0] {
		CFG_FRAME_ROWS = 2'd0,
		CFG_NEAR_THR   = 2'd1,
		CFG_CONTR_THR  = 2'd2,
		CFG_PLATEAU    = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_left;
		logic [PIX_W-1:0] pixel_center;
		logic [PIX_W-1:0] pixel_right;
		logic             frame_start;
	} pix_t;

	typedef struct packed {
		logic [OUT_W-1:0] trough_row;
		logic [OUT_W-1:0] gap_rows;
		logic             first_trough;
	} trough_t;

endpackage
`default_nettype wire

[src/column_trough_spacing_detector.sv]
// top level of the column trough spacing detector
// usage:
//   pix channel (pix_valid / pix_stall / pix) takes one image row per beat: the
//   transect pixel, its left and right neighbours and a frame_start flag for row 0.
//   trough channel (trough_valid / trough_stall / trough) gives one beat per kept
//   trough: its row, the gap from the previous kept trough and a first flag.
//   a row beat tests the row WINDOW_ROWS-2 rows back, so a trough shows up
//   when the row WINDOW_ROWS-2 below it has been taken.
//   a result passes the input stage, then the result register, on its way to the trough
//   port; one row beat per cycle is sustained while the receiver does not stall,
//   set by the single compare stage between the two registers.
//   cfg_we / cfg_index / cfg_data write the four settings; write only while idle.
//   reset clears the windows, the row counter and the trough history and loads
//   the default settings; rows count from reset as if a frame started there.
//   a stalled trough beat holds; pix_stall rises only when the input stage and
//   the result register are both full and the receiver stalls.
`timescale 1ns / 1ps
`default_nettype none
module column_trough_spacing_detector #(
	parameter int MAX_ROWS    = 4096,
	parameter int WINDOW_ROWS = 6
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              pix_valid,
	output logic                                   pix_stall,
	input  wire ctsd_pkg::pix_t                    pix,
	output logic                                   trough_valid,
	input  wire logic                              trough_stall,
	output ctsd_pkg::trough_t                      trough,
	input  wire logic                              cfg_we,
	input  wire logic [ctsd_pkg::CFG_A_W-1:0]      cfg_index,
	input  wire logic [ctsd_pkg::CFG_W-1:0]        cfg_data
);
	import ctsd_pkg::*;

	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int CW    = ((ROW_W > CFG_W) ? ROW_W : CFG_W) + 1;
	localparam int GW    = (ROW_W > OUT_W) ? ROW_W : OUT_W;
	localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(MAX_ROWS - 1);

	// settings
	logic [12:0] frame_rows_q;
	logic [7:0]  near_thr_q;
	logic [7:0]  contr_thr_q;
	logic [11:0] plateau_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_rows_q <= FRAME_ROWS_RST;
			near_thr_q   <= NEAR_THR_RST;
			contr_thr_q  <= CONTR_THR_RST;
			plateau_q    <= PLATEAU_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_FRAME_ROWS: frame_rows_q <= cfg_data;
				CFG_NEAR_THR:   near_thr_q   <= cfg_data[7:0];
				CFG_CONTR_THR:  contr_thr_q  <= cfg_data[7:0];
				CFG_PLATEAU:    plateau_q    <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// handshake
	logic acc;
	logic adv;
	logic valid_s1;
	logic out_valid_q;

	assign pix_stall    = valid_s1 && out_valid_q && trough_stall;
	assign acc          = pix_valid && !pix_stall;
	assign adv          = valid_s1 && (!out_valid_q || !trough_stall);
	assign trough_valid = out_valid_q;

	// windows and row counter, updated on each row beat
	logic [WINDOW_ROWS-1:0][PIX_W-1:0] win_l_q;
	logic [WINDOW_ROWS-1:0][PIX_W-1:0] win_c_q;
	logic [WINDOW_ROWS-1:0][PIX_W-1:0] win_r_q;
	logic [ROW_W-1:0]                  row_cnt_q;
	logic [ROW_W-1:0]                  r_row;
	logic                              test_ok;
	logic [ROW_W-1:0]                  y_s1;
	logic                              test_s1;
	logic                              frame_s1;

	assign r_row   = pix.frame_start ? '0 : row_cnt_q;
	assign test_ok = (r_row < ROW_MAX) && (r_row >= ROW_W'(WINDOW_ROWS - 1))
		&& ((CW'(r_row) + CW'(2)) <= CW'(frame_rows_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_l_q   <= '0;
			win_c_q   <= '0;
			win_r_q   <= '0;
			row_cnt_q <= '0;
			valid_s1  <= 1'b0;
		end else begin
			if (acc) begin
				win_l_q   <= {pix.pixel_left,   win_l_q[WINDOW_ROWS-1:1]};
				win_c_q   <= {pix.pixel_center, win_c_q[WINDOW_ROWS-1:1]};
				win_r_q   <= {pix.pixel_right,  win_r_q[WINDOW_ROWS-1:1]};
				row_cnt_q <= (r_row < ROW_MAX) ? r_row + ROW_W'(1) : ROW_MAX;
				valid_s1  <= 1'b1;
			end else if (adv) begin
				valid_s1  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			y_s1     <= r_row - ROW_W'(WINDOW_ROWS - 2);
			test_s1  <= test_ok;
			frame_s1 <= pix.frame_start;
		end
	end

	// column tests on the shifted windows
	logic pass_l;
	logic pass_c;
	logic pass_r;

	ctsd_col #(.WINDOW_ROWS(WINDOW_ROWS)) u_col_l (
		.win(win_l_q), .near_thr(near_thr_q), .contr_thr(contr_thr_q), .pass(pass_l)
	);
	ctsd_col #(.WINDOW_ROWS(WINDOW_ROWS)) u_col_c (
		.win(win_c_q), .near_thr(near_thr_q), .contr_thr(contr_thr_q), .pass(pass_c)
	);
	ctsd_col #(.WINDOW_ROWS(WINDOW_ROWS)) u_col_r (
		.win(win_r_q), .near_thr(near_thr_q), .contr_thr(contr_thr_q), .pass(pass_r)
	);

	// plateau filter and result register
	logic             have_kept_q;
	logic [ROW_W-1:0] last_kept_q;
	logic             have_eff;
	logic [ROW_W-1:0] last_eff;
	logic [ROW_W-1:0] gap;
	logic [GW-1:0]    gap_ext;
	logic [GW-1:0]    y_ext;
	logic             hit;
	logic             emit;

	assign have_eff = frame_s1 ? 1'b0 : have_kept_q;
	assign last_eff = frame_s1 ? '0 : last_kept_q;
	assign gap      = y_s1 - last_eff;
	assign gap_ext  = GW'(gap);
	assign y_ext    = GW'(y_s1);
	assign hit      = test_s1 && pass_c && (pass_l || pass_r);
	assign emit     = hit && !(have_eff && (gap_ext < GW'(plateau_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_kept_q <= 1'b0;
			last_kept_q <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= emit;
			if (emit) begin
				have_kept_q <= 1'b1;
				last_kept_q <= y_s1;
			end else begin
				have_kept_q <= have_eff;
				last_kept_q <= last_eff;
			end
		end else if (out_valid_q && !trough_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			trough.trough_row   <= y_ext[OUT_W-1:0];
			trough.gap_rows     <= have_eff ? gap_ext[OUT_W-1:0] : '0;
			trough.first_trough <= !have_eff;
		end
	end

	// checks
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> (valid_s1 && out_valid_q))
		else $error("input stalled with a free stage");

	a_first_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(trough_valid && trough.first_trough) |-> (trough.gap_rows == '0))
		else $error("first trough with nonzero gap");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && pix.frame_start) |=> (row_cnt_q == ROW_W'(1)))
		else $error("row counter did not restart on frame start");

	a_kept_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && emit) |=> (have_kept_q && trough_valid && (last_kept_q == $past(y_s1))))
		else $error("trough history not updated on emit");

endmodule
`default_nettype wire

[src/ctsd_col.sv]
// per-column window test: tested row near the window minimum and well below its maximum
`timescale 1ns / 1ps
`default_nettype none
module ctsd_col #(
	parameter int WINDOW_ROWS = 6
) (
	input  wire logic [WINDOW_ROWS-1:0][ctsd_pkg::PIX_W-1:0] win,
	input  wire logic [ctsd_pkg::PIX_W-1:0]                  near_thr,
	input  wire logic [ctsd_pkg::PIX_W-1:0]                  contr_thr,
	output logic                                              pass
);
	import ctsd_pkg::*;

	logic [PIX_W-1:0] lo;
	logic [PIX_W-1:0] hi;
	logic [PIX_W-1:0] val;

	always_comb begin
		lo = win[0];
		hi = win[0];
		for (int k = 1; k < WINDOW_ROWS; k++) begin
			if (win[k] < lo) begin
				lo = win[k];
			end
			if (win[k] > hi) begin
				hi = win[k];
			end
		end
	end

	// tested row sits one slot above the oldest
	assign val  = win[1];
	assign pass = ((val - lo) < near_thr) && ((hi - val) > contr_thr);

endmodule
`default_nettype wire
